// ===== hw/rtl/pan_tilt_tracking_speed_control_assert.svh =====
// ---------------------------------------------------------------------------
// Pan/tilt speed control assertion macros
// Concurrent assertion wrappers clocked on clk and disabled by rst.
// ---------------------------------------------------------------------------
`ifndef PAN_TILT_TRACKING_SPEED_CONTROL_ASSERT_SVH
`define PAN_TILT_TRACKING_SPEED_CONTROL_ASSERT_SVH

`ifndef SYNTHESIS

`define PTSC_ASSERT_ALW(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("ptsc assertion failed");

`define PTSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ptsc assertion failed");

`define PTSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ptsc assertion failed");

`else

`define PTSC_ASSERT_ALW(lbl, expr)
`define PTSC_ASSERT_IMP(lbl, ante, cons)
`define PTSC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== hw/rtl/ptsc_pkg.sv =====
// ---------------------------------------------------------------------------
// Pan/tilt speed control package
// Widths, register indexes, codes, gains and shared types.
// ---------------------------------------------------------------------------
package ptsc_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int TIME_BITS_DEF  = 32;

  localparam int REG_W   = 10;
  localparam int IDX_W   = 3;
  localparam int DIR_W   = 3;
  localparam int SPEED_W = 7;
  localparam int WAY_W   = 2;

  localparam logic [IDX_W-1:0] REG_CENTER_X    = 3'd0;
  localparam logic [IDX_W-1:0] REG_CENTER_Y    = 3'd1;
  localparam logic [IDX_W-1:0] REG_DEAD_ZONE_X = 3'd2;
  localparam logic [IDX_W-1:0] REG_DEAD_ZONE_Y = 3'd3;
  localparam logic [IDX_W-1:0] REG_AXIS_BIAS   = 3'd4;

  localparam logic [REG_W-1:0] CENTER_X_RST    = 10'd384;
  localparam logic [REG_W-1:0] CENTER_Y_RST    = 10'd288;
  localparam logic [REG_W-1:0] DEAD_ZONE_X_RST = 10'd50;
  localparam logic [REG_W-1:0] DEAD_ZONE_Y_RST = 10'd20;
  localparam logic [REG_W-1:0] AXIS_BIAS_RST   = 10'd100;

  localparam logic [WAY_W-1:0] WAY_NONE = 2'd0;
  localparam logic [WAY_W-1:0] WAY_POS  = 2'd1;
  localparam logic [WAY_W-1:0] WAY_NEG  = 2'd2;

  localparam logic [DIR_W-1:0] DIR_CENTER    = 3'd0;
  localparam logic [DIR_W-1:0] DIR_PAN_RIGHT = 3'd1;
  localparam logic [DIR_W-1:0] DIR_PAN_LEFT  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_TILT_UP   = 3'd3;
  localparam logic [DIR_W-1:0] DIR_TILT_DOWN = 3'd4;

  localparam int PAN_EDGE_HI  = 550;
  localparam int PAN_EDGE_LO  = 200;
  localparam int TILT_EDGE_HI = 450;
  localparam int TILT_EDGE_LO = 125;

  localparam int PAN_FOLLOW_GAIN  = 50;
  localparam int PAN_REV_GAIN     = 2;
  localparam int TILT_FOLLOW_GAIN = 100;
  localparam int TILT_REV_GAIN    = 3;

  localparam logic [SPEED_W-1:0] CAP_STD     = 7'd63;
  localparam logic [SPEED_W-1:0] CAP_PAN_REV = 7'd43;
  localparam logic [SPEED_W-1:0] ADD_STD     = 7'd1;
  localparam logic [SPEED_W-1:0] ADD_PAN_REV = 7'd21;

  localparam logic [SPEED_W-1:0] SPEED_SAT        = 7'd63;
  localparam logic [SPEED_W-1:0] SPEED_HELD_MAX   = 7'd64;
  localparam logic [SPEED_W-1:0] SPEED_ZERO       = 7'd0;
  localparam logic [SPEED_W-1:0] PAN_EDGE_SPEED   = 7'd8;
  localparam logic [SPEED_W-1:0] TILT_EDGE_FOLLOW = 7'd20;
  localparam logic [SPEED_W-1:0] TILT_EDGE_REV    = 7'd45;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hw/rtl/ptsc_in_if.sv =====
// ---------------------------------------------------------------------------
// Pan/tilt speed control input channel
// Valid/ready channel carrying one tracked box and its timestamp.
// ---------------------------------------------------------------------------
interface ptsc_in_if #(
  parameter int COORD_BITS = 10,
  parameter int TIME_BITS  = 32
);
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [COORD_BITS-1:0] box_x;
  logic [COORD_BITS-1:0] box_y;
  logic [COORD_BITS-1:0] box_width;
  logic [COORD_BITS-1:0] box_height;
  logic [TIME_BITS-1:0]  timestamp;

  modport source (
    output valid, action, box_x, box_y, box_width, box_height, timestamp,
    input  ready
  );

  modport sink (
    input  valid, action, box_x, box_y, box_width, box_height, timestamp,
    output ready
  );
endinterface

// ===== hw/rtl/ptsc_out_if.sv =====
// ---------------------------------------------------------------------------
// Pan/tilt speed control output channel
// Valid/ready channel carrying direction and held drive speeds.
// ---------------------------------------------------------------------------
interface ptsc_out_if;
  import ptsc_pkg::*;

  logic               valid;
  logic               ready;
  logic [DIR_W-1:0]   direction;
  logic [SPEED_W-1:0] pan_speed;
  logic [SPEED_W-1:0] tilt_speed;

  modport source (
    output valid, direction, pan_speed, tilt_speed,
    input  ready
  );

  modport sink (
    input  valid, direction, pan_speed, tilt_speed,
    output ready
  );
endinterface

// ===== hw/rtl/ptsc_div.sv =====
// ---------------------------------------------------------------------------
// Pan/tilt speed control divider
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`include "pan_tilt_tracking_speed_control_assert.svh"

module ptsc_div
  import ptsc_pkg::*;
#(
  parameter int NUM_W = 17,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output div_stat_t        stat,
  output logic [NUM_W-1:0] quot,
  output logic [DEN_W-1:0] rem
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt;
  logic [DEN_W-1:0] den_r;
  logic             done;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem, quot[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(NUM_W);
      end else if (cnt != '0) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      quot  <= num;
      rem   <= '0;
    end else if (cnt != '0) begin
      if (fits) begin
        rem <= DEN_W'(shifted - {1'b0, den_r});
      end else begin
        rem <= shifted[DEN_W-1:0];
      end
      quot <= {quot[NUM_W-2:0], fits};
    end
  end

  assign stat.busy = cnt != '0;
  assign stat.done = done;

  `PTSC_ASSERT_NXT(a_start_busy, start, stat.busy)
  `PTSC_ASSERT_IMP(a_done_after_busy, done, $past(stat.busy))
  `PTSC_ASSERT_IMP(a_no_start_when_busy, stat.busy, !start)

endmodule

// ===== hw/rtl/pan_tilt_tracking_speed_control.sv =====
// ---------------------------------------------------------------------------
// Pan/tilt tracking speed control
// Turns tracked boxes into a drive direction and held pan/tilt speeds.
//
//   channel    dir  handshake     payload
//   track_in   in   valid/ready   action, box_x, box_y, box_width,
//                                 box_height, timestamp
//   track_out  out  valid/ready   direction, pan_speed, tilt_speed
//   cfg        in   cfg_we        cfg_index, cfg_data
//
// An item passes through accept, evaluate and result when no speed is
// divided, and also through the bit-serial divider loop when one is; the
// divider numerator is NUM_W = max(COORD_BITS, 10) + 7 bits wide.
// One item at a time; the next is accepted while a result waits in the
// output register. Synchronous reset restores register defaults and clears
// all tracking state.
// ---------------------------------------------------------------------------
`include "pan_tilt_tracking_speed_control_assert.svh"

module pan_tilt_tracking_speed_control
  import ptsc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  ptsc_in_if.sink          track_in,
  ptsc_out_if.source       track_out,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  localparam int MW  = (COORD_BITS > REG_W) ? COORD_BITS : REG_W;
  localparam int SW  = MW + 2;
  localparam int AW  = MW + 1;
  localparam int DW  = COORD_BITS + 1;
  localparam int EW  = (COORD_BITS + 1 > 11) ? COORD_BITS + 1 : 11;
  localparam int NUM_W = MW + 7;

  state_t state, state_next;

  logic [REG_W-1:0] center_x, center_y, dead_zone_x, dead_zone_y, axis_bias;

  logic [TIME_BITS-1:0]  prev_time;
  logic [COORD_BITS-1:0] prev_left, prev_top;
  logic [WAY_W-1:0]      pan_way, tilt_way;
  logic [DIR_W-1:0]      last_axis;
  logic [SPEED_W-1:0]    pan_held, tilt_held;

  logic                  action_r;
  logic [COORD_BITS-1:0] bx_r, by_r, bw_r, bh_r;
  logic [TIME_BITS-1:0]  now_r;
  logic [DIR_W-1:0]      dir_r;

  logic               div_pan;
  logic [SPEED_W-1:0] div_cap, div_add;

  logic               out_valid;
  logic [DIR_W-1:0]   out_dir;
  logic [SPEED_W-1:0] out_pan, out_tilt;

  logic in_ready, in_fire, out_load, div_start;

  logic signed [SW-1:0] gx, gy;
  logic [AW-1:0]        ax, ay;
  logic signed [DW-1:0] dx, dy;
  logic [COORD_BITS-1:0] mag_dx, mag_dy;
  logic signed [MW:0]   rx, ry;
  logic [MW-1:0]        mag_rx, mag_ry;
  logic                 dead, pan_sel, gx_pos, gy_pos;
  logic                 follow_x, follow_y, fwd_x, fwd_y, edge_x, edge_y;
  logic                 need_div, dt_zero;
  logic [TIME_BITS-1:0] dt;
  logic [NUM_W-1:0]     num_c;
  logic [SPEED_W-1:0]   cap_c, add_c;
  logic [DIR_W-1:0]     dir_c;

  div_stat_t            div_stat;
  logic [NUM_W-1:0]     quot;
  logic [TIME_BITS-1:0] rem;
  logic                 sat;
  logic [SPEED_W-1:0]   div_speed;

  assign in_fire = track_in.valid && in_ready;

  // evaluate the latched item against tracking state
  always_comb begin
    gx = $signed(SW'(bw_r >> 1) + SW'(bx_r) - SW'(center_x));
    gy = $signed(SW'(bh_r >> 1) + SW'(by_r) - SW'(center_y));
    ax = gx[SW-1] ? AW'(-gx) : AW'(gx);
    ay = gy[SW-1] ? AW'(-gy) : AW'(gy);
    gx_pos = !gx[SW-1] && (gx != '0);
    gy_pos = !gy[SW-1] && (gy != '0);
    dead = (ax <= AW'(dead_zone_x)) && (ay <= AW'(dead_zone_y));
    pan_sel = (AW+1)'(ax) > ((AW+1)'(ay) + (AW+1)'(axis_bias));

    dx = $signed(DW'(bx_r) - DW'(prev_left));
    dy = $signed(DW'(by_r) - DW'(prev_top));
    mag_dx = dx[DW-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    mag_dy = dy[DW-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    rx = $signed((MW+1)'(bx_r) - (MW+1)'(center_x));
    ry = $signed((MW+1)'(by_r) - (MW+1)'(center_y));
    mag_rx = rx[MW] ? MW'(-rx) : MW'(rx);
    mag_ry = ry[MW] ? MW'(-ry) : MW'(ry);

    case (pan_way)
      WAY_POS: begin
        follow_x = !gx[SW-1];
        fwd_x    = !dx[DW-1];
      end
      WAY_NEG: begin
        follow_x = !gx_pos;
        fwd_x    = dx[DW-1] || (dx == '0);
      end
      default: begin
        follow_x = 1'b1;
        fwd_x    = 1'b1;
      end
    endcase

    case (tilt_way)
      WAY_POS: begin
        follow_y = !gy[SW-1];
        fwd_y    = !dy[DW-1];
      end
      WAY_NEG: begin
        follow_y = !gy_pos;
        fwd_y    = dy[DW-1] || (dy == '0);
      end
      default: begin
        follow_y = 1'b1;
        fwd_y    = 1'b1;
      end
    endcase

    edge_x = ((EW'(bx_r) + EW'(bw_r)) > EW'(PAN_EDGE_HI)) ||
             (EW'(bx_r) < EW'(PAN_EDGE_LO));
    edge_y = ((EW'(by_r) + EW'(bh_r)) > EW'(TILT_EDGE_HI)) ||
             (EW'(by_r) < EW'(TILT_EDGE_LO));

    dt      = now_r - prev_time;
    dt_zero = dt == '0;

    if (pan_sel) begin
      dir_c = gx_pos ? DIR_PAN_RIGHT : DIR_PAN_LEFT;
      if (follow_x) begin
        need_div = fwd_x && !edge_x;
        num_c    = NUM_W'(NUM_W'(mag_dx) * NUM_W'(PAN_FOLLOW_GAIN));
        cap_c    = CAP_STD;
        add_c    = ADD_STD;
      end else begin
        need_div = 1'b1;
        num_c    = NUM_W'(NUM_W'(mag_rx) * NUM_W'(PAN_REV_GAIN));
        cap_c    = CAP_PAN_REV;
        add_c    = ADD_PAN_REV;
      end
    end else begin
      dir_c = gy_pos ? DIR_TILT_DOWN : DIR_TILT_UP;
      cap_c = CAP_STD;
      add_c = ADD_STD;
      if (follow_y) begin
        need_div = fwd_y && !edge_y;
        num_c    = NUM_W'(NUM_W'(mag_dy) * NUM_W'(TILT_FOLLOW_GAIN));
      end else begin
        need_div = !edge_y;
        num_c    = NUM_W'(NUM_W'(mag_ry) * NUM_W'(TILT_REV_GAIN));
      end
    end
    if (!action_r || dead) begin
      need_div = 1'b0;
    end
  end

  assign div_start = (state == S_EVAL) && need_div && !dt_zero;

  ptsc_div #(
    .NUM_W (NUM_W),
    .DEN_W (TIME_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_c),
    .den   (dt),
    .stat  (div_stat),
    .quot  (quot),
    .rem   (rem)
  );

  always_comb begin
    sat = (quot > NUM_W'(div_cap)) || ((quot == NUM_W'(div_cap)) && (rem != '0));
    div_speed = sat ? SPEED_SAT : SPEED_W'(quot) + div_add;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (track_in.valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = div_start ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || track_out.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= CENTER_X_RST;
      center_y    <= CENTER_Y_RST;
      dead_zone_x <= DEAD_ZONE_X_RST;
      dead_zone_y <= DEAD_ZONE_Y_RST;
      axis_bias   <= AXIS_BIAS_RST;
      prev_time   <= '0;
      prev_left   <= '0;
      prev_top    <= '0;
      pan_way     <= WAY_NONE;
      tilt_way    <= WAY_NONE;
      last_axis   <= DIR_CENTER;
      pan_held    <= SPEED_ZERO;
      tilt_held   <= SPEED_ZERO;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CENTER_X:    center_x    <= cfg_data;
          REG_CENTER_Y:    center_y    <= cfg_data;
          REG_DEAD_ZONE_X: dead_zone_x <= cfg_data;
          REG_DEAD_ZONE_Y: dead_zone_y <= cfg_data;
          REG_AXIS_BIAS:   axis_bias   <= cfg_data;
          default: ;
        endcase
      end

      if (state == S_EVAL) begin
        if (!action_r) begin
          prev_time <= now_r;
          prev_left <= bx_r;
          prev_top  <= by_r;
          pan_way   <= WAY_NONE;
          tilt_way  <= WAY_NONE;
          last_axis <= DIR_CENTER;
        end else if (dead) begin
          pan_held  <= SPEED_ZERO;
          tilt_held <= SPEED_ZERO;
          prev_time <= now_r;
          prev_left <= bx_r;
          prev_top  <= by_r;
          if (last_axis inside {DIR_PAN_RIGHT, DIR_PAN_LEFT}) begin
            pan_way <= WAY_NONE;
          end else if (last_axis inside {DIR_TILT_UP, DIR_TILT_DOWN}) begin
            tilt_way <= WAY_NONE;
          end else begin
            pan_way  <= WAY_NONE;
            tilt_way <= WAY_NONE;
          end
          last_axis <= DIR_CENTER;
        end else begin
          prev_time <= now_r;
          last_axis <= dir_c;
          if (pan_sel) begin
            pan_way <= gx_pos ? WAY_POS : WAY_NEG;
            if (!follow_x || fwd_x) begin
              prev_left <= bx_r;
              prev_top  <= by_r;
            end
            if (follow_x && edge_x) begin
              pan_held <= PAN_EDGE_SPEED;
            end
            if (need_div && dt_zero) begin
              pan_held <= SPEED_SAT;
            end
          end else begin
            tilt_way <= gy_pos ? WAY_NEG : WAY_POS;
            if (!follow_y || fwd_y) begin
              prev_left <= bx_r;
              prev_top  <= by_r;
            end
            if (edge_y) begin
              tilt_held <= follow_y ? TILT_EDGE_FOLLOW : TILT_EDGE_REV;
            end
            if (need_div && dt_zero) begin
              tilt_held <= SPEED_SAT;
            end
          end
        end
      end

      if ((state == S_DIV) && div_stat.done) begin
        if (div_pan) begin
          pan_held <= div_speed;
        end else begin
          tilt_held <= div_speed;
        end
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (track_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      action_r <= track_in.action;
      bx_r     <= track_in.box_x;
      by_r     <= track_in.box_y;
      bw_r     <= track_in.box_width;
      bh_r     <= track_in.box_height;
      now_r    <= track_in.timestamp;
    end
    if (state == S_EVAL) begin
      dir_r   <= (action_r && !dead) ? dir_c : DIR_CENTER;
      div_pan <= pan_sel;
      div_cap <= cap_c;
      div_add <= add_c;
    end
    if (out_load) begin
      out_dir  <= dir_r;
      out_pan  <= pan_held;
      out_tilt <= tilt_held;
    end
  end

  assign track_in.ready       = in_ready;
  assign track_out.valid      = out_valid;
  assign track_out.direction  = out_dir;
  assign track_out.pan_speed  = out_pan;
  assign track_out.tilt_speed = out_tilt;

  `PTSC_ASSERT_IMP(a_div_only_in_div, div_stat.busy, state == S_DIV)
  `PTSC_ASSERT_NXT(a_accept_to_eval, in_fire, state == S_EVAL)
  `PTSC_ASSERT_ALW(a_pan_speed_range, pan_held <= SPEED_HELD_MAX)
  `PTSC_ASSERT_ALW(a_tilt_speed_range, tilt_held <= SPEED_HELD_MAX)

endmodule
